[hw/rtl/tipi_pkg.sv]
// Shared types and constants for the time indexed position interpolator.
// No dependencies; used by the top level, the division lane and the checker.
package tipi_pkg;

  // Default table depth, in fixes
  localparam int unsigned TableDepthDef = 1024;

  // Command codes
  localparam logic [1:0] CmdAppend = 2'd0;
  localparam logic [1:0] CmdQuery  = 2'd1;
  localparam logic [1:0] CmdClear  = 2'd2;

  // Result status codes
  localparam logic [2:0] StOk    = 3'd0;
  localparam logic [2:0] StNone  = 3'd1;
  localparam logic [2:0] StFull  = 3'd2;
  localparam logic [2:0] StOrder = 3'd3;
  localparam logic [2:0] StEqual = 3'd4;

  // Configuration register indexes and reset
  localparam logic RegMaxGap = 1'b0;
  localparam logic [15:0] MaxGapRst = 16'd1000;

  // One stored fix: time, east, north (north held at its 31-bit width)
  typedef struct packed {
    logic signed [31:0] t;
    logic signed [31:0] e;
    logic signed [30:0] n;
  } fix_t;

  // Work handed to a division lane
  typedef struct packed {
    logic               start;
    logic signed [32:0] delta;
    logic signed [32:0] num;
    logic        [32:0] den;
    logic signed [31:0] base;
  } lane_req_t;

  // Answer from a division lane
  typedef struct packed {
    logic               done;
    logic signed [31:0] value;
  } lane_rsp_t;

endpackage

[hw/rtl/tipi_lane.sv]
// One interpolation lane: base + delta * num / den, truncating, saturated.
// Registered multiply, then a bit-serial restoring divider. Uses tipi_pkg.
module tipi_lane (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tipi_pkg::lane_req_t req_i,
  output tipi_pkg::lane_rsp_t rsp_o
);
  import tipi_pkg::*;

  typedef enum logic [3:0] {
    L_IDLE = 4'b0001,
    L_MUL  = 4'b0010,
    L_DIV  = 4'b0100,
    L_FIN  = 4'b1000
  } lstate_e;

  lstate_e            state_q, state_d;
  logic        [32:0] magd_q, magn_q, den_q;
  logic signed [31:0] base_q;
  logic               neg_q;
  logic        [65:0] dq_q;
  logic        [32:0] rem_q;
  logic        [6:0]  cnt_q;
  logic               done_q;
  logic signed [31:0] value_q;

  // Division step: shift in one dividend bit, subtract where it fits
  logic [33:0] r_sh;
  logic [33:0] r_sub;
  logic        fits;
  assign r_sh  = {rem_q, dq_q[65]};
  assign r_sub = r_sh - {1'b0, den_q};
  assign fits  = (r_sh >= {1'b0, den_q});

  // Quotient clipped well past the saturation point, then signed sum
  logic        [34:0] qc;
  logic signed [35:0] sum;
  logic signed [31:0] sat;
  assign qc  = (|dq_q[65:34]) ? 35'h4_0000_0000 : {1'b0, dq_q[33:0]};
  assign sum = neg_q ? ($signed({{4{base_q[31]}}, base_q}) - $signed({1'b0, qc}))
                     : ($signed({{4{base_q[31]}}, base_q}) + $signed({1'b0, qc}));
  always_comb begin
    if (sum > 36'sd2147483647) begin
      sat = 32'sh7fff_ffff;
    end else if (sum < -36'sd2147483648) begin
      sat = 32'sh8000_0000;
    end else begin
      sat = sum[31:0];
    end
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      L_IDLE: if (req_i.start) state_d = L_MUL;
      L_MUL:  state_d = L_DIV;
      L_DIV:  if (cnt_q == 7'd65) state_d = L_FIN;
      L_FIN:  state_d = L_IDLE;
      default: state_d = L_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= L_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == L_IDLE && req_i.start) begin
        done_q <= 1'b0;
      end else if (state_q == L_FIN) begin
        done_q <= 1'b1;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      L_IDLE: begin
        if (req_i.start) begin
          magd_q <= req_i.delta[32] ? (33'd0 - req_i.delta) : req_i.delta;
          magn_q <= req_i.num[32] ? (33'd0 - req_i.num) : req_i.num;
          den_q  <= req_i.den;
          base_q <= req_i.base;
          neg_q  <= req_i.delta[32] ^ req_i.num[32];
        end
      end
      L_MUL: begin
        dq_q  <= magd_q * magn_q;
        rem_q <= '0;
        cnt_q <= '0;
      end
      L_DIV: begin
        rem_q <= fits ? r_sub[32:0] : r_sh[32:0];
        dq_q  <= {dq_q[64:0], fits};
        cnt_q <= cnt_q + 7'd1;
      end
      L_FIN: value_q <= sat;
      default: ;
    endcase
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.value = value_q;

endmodule

[hw/rtl/time_indexed_position_interpolator.sv]
// Top level of the time indexed position interpolator: fix table memory,
// search sequencer, configuration port. Uses tipi_pkg and tipi_lane.
//
//   channel  | direction | handshake              | word
//   input    | in        | in_valid_i/in_ready_o  | command, time_ms, east_in, north_in
//   output   | out       | out_valid_o/out_ready_i| status, east_out, north_out
//   config   | in        | psel/penable/pready    | max_gap_ms at byte address 0
//
// Append, clear and unused commands pass through the accept cycle and the
// output load. A query adds, as needed, a binary search on the single memory
// port, fix reads and set-up and the work in the division lanes. One word is
// in work at a time; the next is taken while a finished result waits at the
// output, and a result that cannot be loaded holds the sequencer. Reset
// empties the table.
module time_indexed_position_interpolator #(
  parameter int unsigned TABLE_DEPTH = tipi_pkg::TableDepthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         command_i,
  input  logic signed [31:0] time_ms_i,
  input  logic signed [31:0] east_in_i,
  input  logic signed [30:0] north_in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [2:0]         status_o,
  output logic signed [31:0] east_out_o,
  output logic signed [31:0] north_out_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import tipi_pkg::*;

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam logic [CW-1:0] DepthC = CW'(TABLE_DEPTH);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_SRD  = 9'b000000010,
    S_SCMP = 9'b000000100,
    S_RDA  = 9'b000001000,
    S_RDB  = 9'b000010000,
    S_GETB = 9'b000100000,
    S_CALC = 9'b001000000,
    S_DIV  = 9'b010000000,
    S_PUT  = 9'b100000000
  } state_e;

  state_e             state_q;
  logic [CW-1:0]      count_q, lo_q, hi_q;
  logic [AW-1:0]      mid_q, idx_q;
  logic signed [31:0] last_q, time_q;
  logic [15:0]        gap_q;
  fix_t               a_q;
  logic signed [32:0] den_q, num_q, de_q, dn_q;
  logic [2:0]         res_st_q;
  logic signed [31:0] res_e_q, res_n_q;
  logic               ovalid_q;
  logic [2:0]         ost_q;
  logic signed [31:0] oe_q, on_q;

  // Fix table: one port, written only on an append in idle, so a write never
  // overlaps a read of the same entry
  fix_t          mem [TABLE_DEPTH];
  fix_t          rdata_q;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_addr;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_addr] <= fix_t'{t: time_ms_i, e: east_in_i, n: north_in_i};
    end
    if (mem_re) begin
      rdata_q <= mem[mem_addr];
    end
  end

  // Configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == RegMaxGap) ? {16'd0, gap_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_q <= MaxGapRst;
    end else if (psel && penable && pwrite && paddr[2] == RegMaxGap) begin
      gap_q <= pwdata[15:0];
    end
  end

  // Handshakes
  logic acc, slot_free;
  assign in_ready_o = (state_q == S_IDLE);
  assign acc        = in_valid_i && in_ready_o;
  assign slot_free  = !ovalid_q || out_ready_i;

  // Search step and helpers
  logic [CW-1:0]      mid_c, mid_w, lo_n, hi_n;
  logic               below;
  logic signed [32:0] gap_c;
  logic [AW-1:0]      last_idx;
  logic               gap_ok;
  assign mid_c    = lo_q + ((hi_q - lo_q) >> 1);
  assign mid_w    = CW'(mid_q);
  assign below    = (rdata_q.t < time_q);
  assign lo_n     = below ? (mid_w + CW'(1)) : lo_q;
  assign hi_n     = below ? hi_q : mid_w;
  assign gap_c    = 33'(time_ms_i) - 33'(last_q);
  assign gap_ok   = (gap_c <= $signed({17'd0, gap_q}));
  assign last_idx = AW'(count_q - CW'(1));

  // Memory port control
  always_comb begin
    mem_we   = 1'b0;
    mem_re   = 1'b0;
    mem_addr = idx_q;
    case (state_q)
      S_IDLE: begin
        mem_addr = count_q[AW-1:0];
        mem_we   = acc && command_i == CmdAppend && count_q < DepthC &&
                   (count_q == '0 || time_ms_i >= last_q);
      end
      S_SRD: begin
        mem_addr = mid_c[AW-1:0];
        mem_re   = 1'b1;
      end
      S_RDA: mem_re = 1'b1;
      S_RDB: begin
        mem_addr = idx_q + AW'(1);
        mem_re   = (idx_q != last_idx);
      end
      default: ;
    endcase
  end

  // Division lanes, one for each coordinate
  lane_req_t req_e, req_n;
  lane_rsp_t rsp_e, rsp_n;
  logic      start;
  assign start = (state_q == S_CALC) && (den_q != '0);
  assign req_e = lane_req_t'{start: start, delta: de_q, num: num_q,
                             den: den_q, base: a_q.e};
  assign req_n = lane_req_t'{start: start, delta: dn_q, num: num_q,
                             den: den_q, base: 32'(a_q.n)};

  tipi_lane u_lane_e (.clk_i, .rst_ni, .req_i(req_e), .rsp_o(rsp_e));
  tipi_lane u_lane_n (.clk_i, .rst_ni, .req_i(req_n), .rsp_o(rsp_n));

  // Sequencer and control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      ovalid_q <= 1'b0;
    end else begin
      if (ovalid_q && out_ready_i) ovalid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (acc) begin
            state_q <= S_PUT;
            if (mem_we) count_q <= count_q + CW'(1);
            if (command_i == CmdClear) count_q <= '0;
            if (command_i == CmdQuery && count_q != '0) begin
              if (time_ms_i > last_q) begin
                if (gap_ok) state_q <= S_RDA;
              end else begin
                state_q <= S_SRD;
              end
            end
          end
        end
        S_SRD:  state_q <= S_SCMP;
        S_SCMP: state_q <= (lo_n == hi_n) ? S_RDA : S_SRD;
        S_RDA:  state_q <= S_RDB;
        S_RDB:  state_q <= (idx_q == last_idx) ? S_PUT : S_GETB;
        S_GETB: state_q <= S_CALC;
        S_CALC: state_q <= (den_q == '0) ? S_PUT : S_DIV;
        S_DIV:  if (rsp_e.done && rsp_n.done) state_q <= S_PUT;
        S_PUT: begin
          if (slot_free) begin
            ovalid_q <= 1'b1;
            state_q  <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (acc) begin
          time_q   <= time_ms_i;
          res_st_q <= StNone;
          res_e_q  <= '0;
          res_n_q  <= '0;
          lo_q     <= '0;
          hi_q     <= count_q;
          idx_q    <= last_idx;
          if (mem_we) last_q <= time_ms_i;
          case (command_i)
            CmdAppend: begin
              if (count_q >= DepthC)   res_st_q <= StFull;
              else if (!mem_we)        res_st_q <= StOrder;
              else                     res_st_q <= StOk;
            end
            CmdClear: res_st_q <= StOk;
            default: ;
          endcase
        end
      end
      S_SRD: begin
        mid_q <= mid_c[AW-1:0];
      end
      S_SCMP: begin
        lo_q  <= lo_n;
        hi_q  <= hi_n;
        idx_q <= lo_n[AW-1:0];
      end
      S_RDB: begin
        a_q      <= rdata_q;
        res_st_q <= StOk;
        res_e_q  <= rdata_q.e;
        res_n_q  <= 32'(rdata_q.n);
      end
      S_GETB: begin
        den_q <= 33'(rdata_q.t) - 33'(a_q.t);
        num_q <= 33'(time_q) - 33'(a_q.t);
        de_q  <= 33'(rdata_q.e) - 33'(a_q.e);
        dn_q  <= 33'(rdata_q.n) - 33'(a_q.n);
      end
      S_CALC: begin
        if (den_q == '0) res_st_q <= StEqual;
      end
      S_DIV: begin
        res_e_q <= rsp_e.value;
        res_n_q <= rsp_n.value;
      end
      S_PUT: begin
        if (slot_free) begin
          ost_q <= res_st_q;
          oe_q  <= res_e_q;
          on_q  <= res_n_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o = ovalid_q;
  assign status_o    = ost_q;
  assign east_out_o  = oe_q;
  assign north_out_o = on_q;

endmodule

[hw/rtl/tipi_chk.sv]
// Port-level checker for the interpolator, bound to the top level.
// Uses tipi_pkg for the status codes.
module tipi_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic [2:0]         status_o,
  input logic signed [31:0] east_out_o,
  input logic signed [31:0] north_out_o,
  input logic               pready
);
  import tipi_pkg::*;

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) &&
    $stable(east_out_o) && $stable(north_out_o))
    else $error("result word changed while stalled");

  // Results with status none, full or order carry no coordinates
  a_zero_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == StNone || status_o == StFull ||
    status_o == StOrder) |-> east_out_o == 0 && north_out_o == 0)
    else $error("coordinates on a failed result");

  // One word in work at a time
  a_one_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input taken while a word is in work");

  // Register port never waits
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready low");

endmodule

bind time_indexed_position_interpolator tipi_chk u_tipi_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .status_o    (status_o),
  .east_out_o  (east_out_o),
  .north_out_o (north_out_o),
  .pready      (pready)
);
